// File: hw/rtl/mkqs_pkg.sv
// ----------------------------------------------------------------------------
// mkqs_pkg
// Shared types, constants and the record compare function of the sorter.
// ----------------------------------------------------------------------------
package mkqs_pkg;

  localparam int MAX_RECORDS     = 64;
  localparam int STACK_DEPTH     = 8;
  localparam int KEY_COUNT       = 3;
  localparam int SMALL_SET_LIMIT = 8;
  localparam int KEY_W           = 32;

  localparam int IDX_W  = $clog2(MAX_RECORDS);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);

  localparam int CFG_AW = 1;
  localparam int CFG_W  = 3;
  localparam logic [CFG_AW-1:0] CFG_CRITERIA = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_DESCEND  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]                payload;
    logic [KEY_COUNT-1:0][KEY_W-1:0] keys;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [1:0] {
    ORD_LT,
    ORD_EQ,
    ORD_GT
  } ord_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEL_TOP,
    ST_SEL_LD,
    ST_SEL_RD,
    ST_SEL_CMP,
    ST_SEL_NEXT,
    ST_QS_PART,
    ST_QS_PIVR,
    ST_QS_PIVL,
    ST_QS_UP,
    ST_QS_UPC,
    ST_QS_DN,
    ST_QS_DNC,
    ST_QS_CHK,
    ST_QS_SPLIT,
    ST_QS_POP,
    ST_XA,
    ST_XB,
    ST_XC,
    ST_OUT_RD,
    ST_OUT_VAL
  } state_e;

  // key 0 decides first; later keys only break ties
  function automatic ord_e rec_order(rec_t a, rec_t b, logic [1:0] crit,
                                     logic [KEY_COUNT-1:0] mask);
    int   n;
    ord_e res;
    n = (crit == 2'd0) ? 1 : int'(crit);
    if (n > KEY_COUNT) n = KEY_COUNT;
    res = ORD_EQ;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (k < n && a.keys[k] != b.keys[k]) begin
        res = ((a.keys[k] > b.keys[k]) ^ mask[k]) ? ORD_GT : ORD_LT;
      end
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/multi_key_quicksort.sv
// ----------------------------------------------------------------------------
// multi_key_quicksort
// Loads records until tlast, sorts them in place with one shared compare unit
// (selection sort up to nine records, quicksort with range stack above), and
// streams them out in order.
// Loading: one record per cycle. Sorting runs on a single record RAM with two
// read ports and one write port; an exchange reads both records, then writes
// them back one after the other. Output: each record is read, then held valid
// until taken. Input is not ready from tlast until the last result is taken.
// Reset initialises control state and config; record RAM holds no reset value.
// ----------------------------------------------------------------------------
module multi_key_quicksort
  import mkqs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // key_first, key_second, key_third, payload
  input  logic [REC_W-1:0]  s_axis_tdata,
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_key_first, out_key_second, out_key_third, out_payload
  output logic [REC_W-1:0]  m_axis_tdata,
  output logic              m_axis_tlast
);

  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] SMALL_CNT = CNT_W'(SMALL_SET_LIMIT + 1);
  localparam logic [SP_W-1:0]  STK_FULL  = SP_W'(STACK_DEPTH);

  state_e state_q, state_d, ret_q, ret_d;
  logic [1:0] crit_q;
  logic [KEY_COUNT-1:0] mask_q;
  logic [CNT_W-1:0] count_q, count_d, n_q, n_d, k_q, k_d;
  logic [CNT_W-1:0] up_q, up_d, down_q, down_d, p_q, p_d;
  logic [IDX_W-1:0] lo_q, lo_d, hi_q, hi_d, best_q, best_d, xa_q, xa_d, xb_q, xb_d;
  rec_t ref_q, ref_d, tmp_q, tmp_d;
  logic [SP_W-1:0] sp_q, sp_d;
  logic [IDX_W-1:0] stk_lo_q [STACK_DEPTH];
  logic [IDX_W-1:0] stk_hi_q [STACK_DEPTH];
  logic push_en;
  logic [IDX_W-1:0] push_lo, push_hi;

  logic we;
  logic [IDX_W-1:0] waddr, ra, rb;
  rec_t wdata, qa, qb;
  ord_e ord;

  logic [CNT_W-1:0] size, u, d, n_in, span_a, span_b;
  logic c_lo, c_up;

  mkqs_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (qa),
    .rdata_b_o (qb)
  );

  assign ord  = rec_order(qa, ref_q, crit_q, mask_q);
  assign size = {1'b0, hi_q} - {1'b0, lo_q} + CNT_W'(1);
  assign u    = up_q + CNT_W'(1);
  assign d    = down_q - CNT_W'(1);
  assign n_in = (count_q < MAX_CNT) ? count_q + CNT_W'(1) : count_q;
  assign span_a = down_q - {1'b0, lo_q};
  assign span_b = {1'b0, hi_q} + CNT_W'(1) - up_q;
  assign c_lo = ({1'b0, lo_q} + CNT_W'(1)) < down_q;
  assign c_up = up_q < {1'b0, hi_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT_VAL);
  assign m_axis_tdata  = qa;
  assign m_axis_tlast  = (k_q == n_q - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      crit_q  <= 2'd1;
      mask_q  <= '0;
      count_q <= '0;
      n_q     <= '0;
      k_q     <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      count_q <= count_d;
      n_q     <= n_d;
      k_q     <= k_d;
      sp_q    <= sp_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_CRITERIA: crit_q <= cfg_wdata_i[1:0];
          CFG_DESCEND:  mask_q <= cfg_wdata_i[KEY_COUNT-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    up_q   <= up_d;
    down_q <= down_d;
    p_q    <= p_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    best_q <= best_d;
    xa_q   <= xa_d;
    xb_q   <= xb_d;
    ref_q  <= ref_d;
    tmp_q  <= tmp_d;
    if (push_en) begin
      stk_lo_q[sp_q[STK_AW-1:0]] <= push_lo;
      stk_hi_q[sp_q[STK_AW-1:0]] <= push_hi;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    count_d = count_q;
    n_d     = n_q;
    k_d     = k_q;
    sp_d    = sp_q;
    up_d    = up_q;
    down_d  = down_q;
    p_d     = p_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    best_d  = best_q;
    xa_d    = xa_q;
    xb_d    = xb_q;
    ref_d   = ref_q;
    tmp_d   = tmp_q;
    push_en = 1'b0;
    push_lo = lo_q;
    push_hi = hi_q;
    we      = 1'b0;
    waddr   = count_q[IDX_W-1:0];
    wdata   = s_axis_tdata;
    ra      = k_q[IDX_W-1:0];
    rb      = xb_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (count_q < MAX_CNT) begin
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            n_d  = n_in;
            lo_d = '0;
            hi_d = IDX_W'(n_in - CNT_W'(1));
            state_d = (n_in <= SMALL_CNT) ? ST_SEL_TOP : ST_QS_PART;
          end
        end
      end
      ST_SEL_TOP: begin
        ra = '0;
        if (hi_q != '0) begin
          state_d = ST_SEL_LD;
        end else begin
          k_d = '0;
          state_d = ST_OUT_RD;
        end
      end
      ST_SEL_LD: begin
        ref_d   = qa;
        best_d  = '0;
        p_d     = CNT_W'(1);
        state_d = ST_SEL_RD;
      end
      ST_SEL_RD: begin
        ra = p_q[IDX_W-1:0];
        state_d = ST_SEL_CMP;
      end
      ST_SEL_CMP: begin
        ra = p_q[IDX_W-1:0];
        xa_d = best_q;
        if (ord == ORD_GT) begin
          best_d = p_q[IDX_W-1:0];
          ref_d  = qa;
          xa_d   = p_q[IDX_W-1:0];
        end
        if (p_q[IDX_W-1:0] == hi_q) begin
          xb_d    = hi_q;
          ret_d   = ST_SEL_NEXT;
          state_d = ST_XA;
        end else begin
          p_d     = p_q + CNT_W'(1);
          state_d = ST_SEL_RD;
        end
      end
      ST_SEL_NEXT: begin
        hi_d    = hi_q - IDX_W'(1);
        state_d = ST_SEL_TOP;
      end
      ST_QS_PART: begin
        xa_d    = lo_q + size[IDX_W:1];
        xb_d    = lo_q;
        ret_d   = ST_QS_PIVR;
        state_d = ST_XA;
      end
      ST_QS_PIVR: begin
        ra = lo_q;
        state_d = ST_QS_PIVL;
      end
      ST_QS_PIVL: begin
        ref_d   = qa;
        up_d    = {1'b0, lo_q};
        down_d  = {1'b0, hi_q} + CNT_W'(1);
        state_d = ST_QS_UP;
      end
      ST_QS_UP: begin
        up_d = u;
        ra   = u[IDX_W-1:0];
        state_d = (u > {1'b0, hi_q}) ? ST_QS_DN : ST_QS_UPC;
      end
      ST_QS_UPC: begin
        ra = up_q[IDX_W-1:0];
        state_d = (ord != ORD_GT) ? ST_QS_UP : ST_QS_DN;
      end
      ST_QS_DN: begin
        down_d = d;
        ra     = d[IDX_W-1:0];
        state_d = (d > {1'b0, lo_q}) ? ST_QS_DNC : ST_QS_CHK;
      end
      ST_QS_DNC: begin
        ra = down_q[IDX_W-1:0];
        state_d = (ord != ORD_LT) ? ST_QS_DN : ST_QS_CHK;
      end
      ST_QS_CHK: begin
        xb_d = down_q[IDX_W-1:0];
        if (down_q < up_q) begin
          xa_d  = lo_q;
          ret_d = ST_QS_SPLIT;
        end else begin
          xa_d  = up_q[IDX_W-1:0];
          ret_d = ST_QS_UP;
        end
        state_d = ST_XA;
      end
      ST_QS_SPLIT: begin
        state_d = ST_QS_POP;
        if (span_a >= span_b) begin
          push_en = c_lo;
          push_lo = lo_q;
          push_hi = IDX_W'(down_q - CNT_W'(1));
          if (c_up) begin
            lo_d    = up_q[IDX_W-1:0];
            state_d = ST_QS_PART;
          end
        end else begin
          push_en = c_up;
          push_lo = up_q[IDX_W-1:0];
          push_hi = hi_q;
          if (c_lo) begin
            hi_d    = IDX_W'(down_q - CNT_W'(1));
            state_d = ST_QS_PART;
          end
        end
        if (sp_q == STK_FULL) begin
          push_en = 1'b0;
        end
        if (push_en) begin
          sp_d = sp_q + SP_W'(1);
        end
      end
      ST_QS_POP: begin
        if (sp_q == '0) begin
          k_d = '0;
          state_d = ST_OUT_RD;
        end else begin
          sp_d    = sp_q - SP_W'(1);
          lo_d    = stk_lo_q[sp_d[STK_AW-1:0]];
          hi_d    = stk_hi_q[sp_d[STK_AW-1:0]];
          state_d = ST_QS_PART;
        end
      end
      ST_XA: begin
        ra = xa_q;
        rb = xb_q;
        state_d = ST_XB;
      end
      ST_XB: begin
        we    = 1'b1;
        waddr = xa_q;
        wdata = qb;
        tmp_d = qa;
        state_d = ST_XC;
      end
      ST_XC: begin
        we    = 1'b1;
        waddr = xb_q;
        wdata = tmp_q;
        state_d = ret_q;
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_VAL;
      end
      ST_OUT_VAL: begin
        if (m_axis_tready) begin
          if (m_axis_tlast) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mkqs_ram.sv
// ----------------------------------------------------------------------------
// mkqs_ram
// Generic RAM: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module mkqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hw/rtl/mkqs_checker.sv
// ----------------------------------------------------------------------------
// mkqs_checker
// Port-level checks of the sorter, bound to the top level.
// ----------------------------------------------------------------------------
module mkqs_checker
  import mkqs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tlast,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [REC_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while results pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after final result");

  a_load_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
    else $error("loading stalled before last request");

endmodule

bind multi_key_quicksort mkqs_checker u_mkqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
